@@ rtl/bpc_pkg.sv @@
// Shared types and constants for the barometer pressure compensation block.
package bpc_pkg;

  // Quotient bits worked out by the divider chain (one bit per cell)
  localparam int Q_W          = 22;
  localparam int PRES_W       = 21;
  localparam int TEMP_W       = 15;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  // Register stages ahead of the divider chain
  localparam int FRONT_STAGES = 8;

  localparam logic [PRES_W-1:0] PRES_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LOW   = 2'd0,
    REG_COEF_MID   = 2'd1,
    REG_COEF_HIGH  = 2'd2,
    REG_OFFSET_MID = 2'd3
  } bpc_reg_t;

  // Control travelling with each request down the pipeline
  typedef struct packed {
    logic valid;
    logic force_zero;
    logic sat;
  } bpc_ctl_t;

endpackage

@@ rtl/bpc_front.sv @@
// Front pipeline: look-up points, cross-ratio products, divider operands.
module bpc_front #(
  parameter int PRESSURE_FRAC_BITS = 4,
  parameter int W_REM              = 139,
  parameter int W_DV               = 113
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [23:0]                  raw_pressure_code,
  input  logic [15:0]                  raw_temperature_code,
  input  logic signed [15:0]           coef_low,
  input  logic signed [15:0]           coef_mid,
  input  logic signed [15:0]           coef_high,
  input  logic signed [15:0]           offset_mid,
  output bpc_pkg::bpc_ctl_t            ctl_o,
  output logic [W_REM-1:0]             rem_o,
  output logic [W_DV-1:0]              dv_o,
  output logic [bpc_pkg::TEMP_W-1:0]   temp_o
);

  localparam int NS = bpc_pkg::FRONT_STAGES;
  localparam logic signed [53:0] S_LO_BASE = 54'sd7 <<< 43;
  localparam logic signed [53:0] S_HI_BASE = 54'sd23 <<< 43;

  logic [NS-1:0] v_r;

  // stage 0
  logic signed [15:0] t_s;
  logic signed [31:0] t_sq;
  logic [23:0]        rp0_r;
  logic [15:0]        rt0_r;
  logic [30:0]        t2_r;

  // stage 1
  logic signed [47:0] p_lo_nxt, p_mid_nxt, p_hi_nxt;
  logic signed [47:0] p_lo_r, p_mid_r, p_hi_r;
  logic [31:0]        tw;
  logic [bpc_pkg::TEMP_W-1:0] temp_nxt;
  logic [bpc_pkg::TEMP_W-1:0] tmp_r [1:NS-1];
  logic [23:0]        rp1_r;

  // stage 2
  logic signed [53:0] x_s, s_lo, s_mid, s_hi;
  logic signed [53:0] an_f, bn_f, ad_f, bd_f;
  logic signed [49:0] a_r [2];
  logic signed [52:0] b_r [2];

  // stage 3
  logic [51:0]        ll_nxt [2];
  logic signed [51:0] lh_nxt [2];
  logic signed [52:0] hl_nxt [2];
  logic signed [50:0] hh_nxt [2];
  logic [51:0]        ll_r [2];
  logic signed [51:0] lh_r [2];
  logic signed [52:0] hl_r [2];
  logic signed [50:0] hh_r [2];

  // stage 4
  logic [103:0] prod_nxt [2];
  logic [103:0] prod_r   [2];

  // stage 5
  logic [111:0] nn, dd, num_nxt, den_nxt, num_r, den_r;

  // stage 6
  logic         num_neg, den_neg, num_zero, den_zero, mism;
  logic [111:0] na_nxt, da_nxt, na_r, da_r;
  logic         force6_r, sat6_r;

  // stage 7
  logic [W_REM-1:0] na_w, rem_nxt, rem_r;
  logic [W_DV-1:0]  dv_r;
  logic             force7_r, sat7_r;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], take};
    end
  end

  // stage 0: centered temperature squared
  always_comb begin
    t_s  = $signed({~raw_temperature_code[15], raw_temperature_code[14:0]});
    t_sq = t_s * t_s;
  end

  always_ff @(posedge clk) begin
    rp0_r <= raw_pressure_code;
    rt0_r <= raw_temperature_code;
    t2_r  <= t_sq[30:0];
  end

  // stage 1: quadratic terms and temperature
  always_comb begin
    p_lo_nxt  = coef_low  * $signed({1'b0, t2_r});
    p_mid_nxt = coef_mid  * $signed({1'b0, t2_r});
    p_hi_nxt  = coef_high * $signed({1'b0, t2_r});
    tw        = 32'd17500 * {16'd0, rt0_r} + 32'd32768;
    temp_nxt  = tw[30:16] - 15'd4500;
  end

  always_ff @(posedge clk) begin
    p_lo_r  <= p_lo_nxt;
    p_mid_r <= p_mid_nxt;
    p_hi_r  <= p_hi_nxt;
    rp1_r   <= rp0_r;
    tmp_r[1] <= temp_nxt;
    for (int k = 2; k < NS; k++) begin
      tmp_r[k] <= tmp_r[k-1];
    end
  end

  // stage 2: look-up points and differences
  always_comb begin
    x_s   = $signed({6'd0, rp1_r, 24'd0});
    s_lo  = S_LO_BASE + $signed({{6{p_lo_r[47]}}, p_lo_r});
    s_hi  = S_HI_BASE + $signed({{6{p_hi_r[47]}}, p_hi_r});
    s_mid = $signed({{3{offset_mid[15]}}, offset_mid, 35'd0})
          + $signed({{6{p_mid_r[47]}}, p_mid_r});
    an_f  = x_s - s_lo;
    bn_f  = s_mid - s_hi;
    ad_f  = x_s - s_hi;
    bd_f  = s_mid - s_lo;
  end

  always_ff @(posedge clk) begin
    a_r[0] <= an_f[49:0];
    b_r[0] <= bn_f[52:0];
    a_r[1] <= ad_f[49:0];
    b_r[1] <= bd_f[52:0];
  end

  // stage 3: partial products (index 0 is N, index 1 is D)
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ll_nxt[i] = {27'd0, a_r[i][24:0]} * {25'd0, b_r[i][26:0]};
      lh_nxt[i] = $signed({1'b0, a_r[i][24:0]}) * $signed(b_r[i][52:27]);
      hl_nxt[i] = $signed(a_r[i][49:25]) * $signed({1'b0, b_r[i][26:0]});
      hh_nxt[i] = $signed(a_r[i][49:25]) * $signed(b_r[i][52:27]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      ll_r[i] <= ll_nxt[i];
      lh_r[i] <= lh_nxt[i];
      hl_r[i] <= hl_nxt[i];
      hh_r[i] <= hh_nxt[i];
    end
  end

  // stage 4: sum of partial products
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_nxt[i] = ({{53{hh_r[i][50]}}, hh_r[i]} << 52)
                  + ({{51{hl_r[i][52]}}, hl_r[i]} << 25)
                  + ({{52{lh_r[i][51]}}, lh_r[i]} << 27)
                  + {52'd0, ll_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= prod_nxt[0];
    prod_r[1] <= prod_nxt[1];
  end

  // stage 5: numerator 45D+147N, denominator 5D+7N
  always_comb begin
    nn      = {{8{prod_r[0][103]}}, prod_r[0]};
    dd      = {{8{prod_r[1][103]}}, prod_r[1]};
    num_nxt = (dd << 5) + (dd << 3) + (dd << 2) + dd
            + (nn << 7) + (nn << 4) + (nn << 1) + nn;
    den_nxt = (dd << 2) + dd + (nn << 3) - nn;
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  // stage 6: special cases and magnitudes
  always_comb begin
    num_neg  = num_r[111];
    den_neg  = den_r[111];
    num_zero = (num_r == '0);
    den_zero = (den_r == '0);
    mism     = num_neg ^ den_neg;
    na_nxt   = num_neg ? (112'd0 - num_r) : num_r;
    da_nxt   = den_neg ? (112'd0 - den_r) : den_r;
  end

  always_ff @(posedge clk) begin
    na_r     <= na_nxt;
    da_r     <= da_nxt;
    force6_r <= den_zero | num_zero | mism;
    sat6_r   <= den_zero | (!num_zero & mism);
  end

  // stage 7: dividend 2*5000*2^F*|num| + |den|, divisor 2*|den|
  always_comb begin
    na_w    = W_REM'(na_r);
    rem_nxt = (((na_w << 13) + (na_w << 10) + (na_w << 9) + (na_w << 8) + (na_w << 4))
              << PRESSURE_FRAC_BITS) + W_REM'(da_r);
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    dv_r     <= W_DV'({da_r, 1'b0});
    force7_r <= force6_r;
    sat7_r   <= sat6_r;
  end

  assign ctl_o  = '{valid: v_r[NS-1], force_zero: force7_r, sat: sat7_r};
  assign rem_o  = rem_r;
  assign dv_o   = dv_r;
  assign temp_o = tmp_r[NS-1];

endmodule

@@ rtl/bpc_div_cell.sv @@
// One restoring-division cell: settles one quotient bit and passes on.
module bpc_div_cell #(
  parameter int W_REM = 139,
  parameter int W_DV  = 113,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpc_pkg::bpc_ctl_t             ctl_i,
  input  logic [W_REM-1:0]              rem_i,
  input  logic [W_DV-1:0]               dv_i,
  input  logic [bpc_pkg::Q_W-1:0]       q_i,
  input  logic [bpc_pkg::TEMP_W-1:0]    temp_i,
  output bpc_pkg::bpc_ctl_t             ctl_o,
  output logic [W_REM-1:0]              rem_o,
  output logic [W_DV-1:0]               dv_o,
  output logic [bpc_pkg::Q_W-1:0]       q_o,
  output logic [bpc_pkg::TEMP_W-1:0]    temp_o
);

  logic [W_REM-1:0]           sh;
  logic                       ge;
  logic [W_REM-1:0]           rem_nxt;
  logic [bpc_pkg::Q_W-1:0]    q_nxt;
  bpc_pkg::bpc_ctl_t          ctl_r;
  logic [W_REM-1:0]           rem_r;
  logic [W_DV-1:0]            dv_r;
  logic [bpc_pkg::Q_W-1:0]    q_r;
  logic [bpc_pkg::TEMP_W-1:0] temp_r;

  // trial subtract of the shifted divisor
  always_comb begin
    sh           = W_REM'(dv_i) << SHIFT;
    ge           = (rem_i >= sh);
    rem_nxt      = ge ? (rem_i - sh) : rem_i;
    q_nxt        = q_i;
    q_nxt[SHIFT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dv_r   <= dv_i;
    q_r    <= q_nxt;
    temp_r <= temp_i;
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign dv_o   = dv_r;
  assign q_o    = q_r;
  assign temp_o = temp_r;

endmodule

@@ rtl/barometer_pressure_compensation.sv @@
// Top level: configuration registers, front pipeline, divider cell chain, result register.
// Fully pipelined: a request is taken in every cycle (busy stays low). Its result is put
// on the out_ ports with out_valid after passing 8 front stages, the first of them loaded
// at the accepting edge (squares, 16x31 coefficient products, 4-way split 50x53 products,
// cross-ratio sums, sign handling, dividend build), 22 divider cells producing one
// quotient bit each, and the output register. The receiver cannot stall; each result is
// shown for one cycle only. Configuration writes take effect at once and must be made
// only when no request is in flight.
module barometer_pressure_compensation #(
  parameter int PRESSURE_FRAC_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [23:0]                           in_raw_pressure_code,
  input  logic [15:0]                           in_raw_temperature_code,
  output logic                                  out_valid,
  output logic [bpc_pkg::PRES_W-1:0]            out_pressure_pa_x16,
  output logic signed [bpc_pkg::TEMP_W-1:0]     out_temperature_centideg,
  output logic                                  out_pressure_saturated,
  input  logic                                  cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int W_REM   = 135 + PRESSURE_FRAC_BITS;
  localparam int W_DV    = 113;
  localparam int QW      = bpc_pkg::Q_W;
  localparam int LATENCY = bpc_pkg::FRONT_STAGES + QW + 1;

  logic signed [15:0] coef_low_r, coef_mid_r, coef_high_r, offset_mid_r;

  bpc_pkg::bpc_ctl_t          ctl_c  [QW+1];
  logic [W_REM-1:0]           rem_c  [QW+1];
  logic [W_DV-1:0]            dv_c   [QW+1];
  logic [QW-1:0]              q_c    [QW+1];
  logic [bpc_pkg::TEMP_W-1:0] temp_c [QW+1];

  logic                       take;
  logic [bpc_pkg::PRES_W-1:0] pres_nxt;
  logic                       sat_nxt;
  logic                       out_valid_r;
  logic [bpc_pkg::PRES_W-1:0] pres_r;
  logic [bpc_pkg::TEMP_W-1:0] temp_r;
  logic                       sat_r;

  assign busy = 1'b0;
  assign take = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_low_r   <= '0;
      coef_mid_r   <= '0;
      coef_high_r  <= '0;
      offset_mid_r <= '0;
    end else if (cfg_we) begin
      case (bpc_pkg::bpc_reg_t'(cfg_index))
        bpc_pkg::REG_COEF_LOW:   coef_low_r   <= cfg_wdata;
        bpc_pkg::REG_COEF_MID:   coef_mid_r   <= cfg_wdata;
        bpc_pkg::REG_COEF_HIGH:  coef_high_r  <= cfg_wdata;
        bpc_pkg::REG_OFFSET_MID: offset_mid_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpc_front #(
    .PRESSURE_FRAC_BITS(PRESSURE_FRAC_BITS),
    .W_REM(W_REM),
    .W_DV(W_DV)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .take(take),
    .raw_pressure_code(in_raw_pressure_code),
    .raw_temperature_code(in_raw_temperature_code),
    .coef_low(coef_low_r),
    .coef_mid(coef_mid_r),
    .coef_high(coef_high_r),
    .offset_mid(offset_mid_r),
    .ctl_o(ctl_c[0]),
    .rem_o(rem_c[0]),
    .dv_o(dv_c[0]),
    .temp_o(temp_c[0])
  );

  assign q_c[0] = '0;

  // divider chain, most significant quotient bit first
  for (genvar g = 0; g < QW; g++) begin : g_cell
    bpc_div_cell #(
      .W_REM(W_REM),
      .W_DV(W_DV),
      .SHIFT(QW - 1 - g)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .ctl_i(ctl_c[g]),
      .rem_i(rem_c[g]),
      .dv_i(dv_c[g]),
      .q_i(q_c[g]),
      .temp_i(temp_c[g]),
      .ctl_o(ctl_c[g+1]),
      .rem_o(rem_c[g+1]),
      .dv_o(dv_c[g+1]),
      .q_o(q_c[g+1]),
      .temp_o(temp_c[g+1])
    );
  end

  // result select: special cases, then range clip
  always_comb begin
    if (ctl_c[QW].force_zero) begin
      pres_nxt = '0;
      sat_nxt  = ctl_c[QW].sat;
    end else if (q_c[QW][QW-1:bpc_pkg::PRES_W] != '0) begin
      pres_nxt = bpc_pkg::PRES_MAX;
      sat_nxt  = 1'b1;
    end else begin
      pres_nxt = q_c[QW][bpc_pkg::PRES_W-1:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_c[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
    sat_r  <= sat_nxt;
    temp_r <= temp_c[QW];
  end

  assign out_valid                = out_valid_r;
  assign out_pressure_pa_x16      = pres_r;
  assign out_temperature_centideg = temp_r;
  assign out_pressure_saturated   = sat_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_centideg >= -15'sd4500 &&
                   out_temperature_centideg <= 15'sd13000))
    else $error("temperature out of range");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pressure_saturated) |->
      (out_pressure_pa_x16 == '0 || out_pressure_pa_x16 == bpc_pkg::PRES_MAX))
    else $error("saturated pressure not at a bound");
`endif

endmodule
